FILE: design/wireworld_grid_stepper_assert.svh
// assertion macros used by the wireworld grid stepper controller
`ifndef WIREWORLD_GRID_STEPPER_ASSERT_SVH
`define WIREWORLD_GRID_STEPPER_ASSERT_SVH

// same-cycle implication
`define WWGS_ASSERT_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("wireworld grid stepper check failed");

// next-cycle implication
`define WWGS_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("wireworld grid stepper check failed");

`endif

FILE: design/wwgs_pkg.sv
// types, constants and the cell update function of the wireworld grid stepper
package wwgs_pkg;

    localparam int CFG_W = 7;
    localparam int GEN_W = 16;
    localparam int MIN_DIM = 3;
    localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

    localparam logic [1:0] CELL_BLANK  = 2'd0;
    localparam logic [1:0] CELL_COPPER = 2'd1;
    localparam logic [1:0] CELL_HEAD   = 2'd2;
    localparam logic [1:0] CELL_TAIL   = 2'd3;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_RUN   = 2'd1,
        REQ_READ  = 2'd2
    } req_t;

    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_BAD,
        OUT_CELL
    } out_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic     cell_wr;
        logic     cell_rd;
        logic     run_start;
        logic     sweep;
        logic     gen_end;
        logic     load_out;
        out_sel_t out_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic addr_bad;
        logic gen_zero;
        logic sweep_last;
        logic gens_last;
        logic changed_any;
    } dp_stat_t;

    function automatic logic [1:0] next_cell(input logic [1:0] cur, input logic [7:0] heads);
        logic [3:0] n;
        logic [1:0] res;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + 4'(heads[i]);
        end
        case (cur)
            CELL_BLANK: res = CELL_BLANK;
            CELL_HEAD:  res = CELL_TAIL;
            CELL_TAIL:  res = CELL_COPPER;
            default:    res = (n == 4'd1 || n == 4'd2) ? CELL_HEAD : CELL_COPPER;
        endcase
        return res;
    endfunction

endpackage

FILE: design/wwgs_row_ram.sv
// row-wide grid memory with per-cell write mask and registered read
module wwgs_row_ram #(
    parameter int WORDS = 64,
    parameter int LANES = 64
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [$clog2(WORDS)-1:0]            waddr,
    input  logic [LANES-1:0]                    wmask,
    input  logic [LANES-1:0][1:0]               wdata,
    input  logic                                re,
    input  logic [$clog2(WORDS)-1:0]            raddr,
    output logic [LANES-1:0][1:0]               rdata
);

    logic [LANES-1:0][1:0] mem [WORDS];
    logic [LANES-1:0][1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (wmask[i])
                begin
                    mem[waddr][i] <= wdata[i];
                end
            end
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/wwgs_datapath.sv
// datapath: config registers, ping-pong grid stores, row window and cell update lanes
module wwgs_datapath #(
    parameter int MAX_WIDTH = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [wwgs_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic [5:0]                   row_index,
    input  logic [5:0]                   col_index,
    input  logic [1:0]                   cell_in,
    input  logic [wwgs_pkg::GEN_W-1:0]   generation_count,
    input  wwgs_pkg::dp_cmd_t            cmd,
    output wwgs_pkg::dp_stat_t           stat,
    output logic [1:0]                   cell_out,
    output logic                         status
);

    localparam int W_BITS = $clog2(MAX_WIDTH + 1);
    localparam int H_BITS = $clog2(MAX_HEIGHT + 1);
    localparam int DIM_BITS = (W_BITS > H_BITS) ? W_BITS : H_BITS;
    localparam int CMP_W = (DIM_BITS > wwgs_pkg::CFG_W) ? DIM_BITS : wwgs_pkg::CFG_W;
    localparam int T_W = CMP_W + 1;
    localparam int RA_W = $clog2(MAX_HEIGHT);
    localparam int CA_W = $clog2(MAX_WIDTH);

    logic [wwgs_pkg::CFG_W-1:0]   width_reg;
    logic [wwgs_pkg::CFG_W-1:0]   height_reg;
    logic                         sel_reg;
    logic                         sel_next;
    logic [T_W-1:0]               t_reg;
    logic [T_W-1:0]               t_next;
    logic [wwgs_pkg::GEN_W-1:0]   gen_cnt_reg;
    logic [wwgs_pkg::GEN_W-1:0]   gen_cnt_next;
    logic                         changed_reg;
    logic                         changed_next;
    logic [CA_W-1:0]              col_reg;
    logic [1:0]                   cell_out_reg;
    logic                         status_reg;

    logic [MAX_WIDTH-1:0][1:0]    above_reg;
    logic [MAX_WIDTH-1:0][1:0]    mid_reg;
    logic [MAX_WIDTH-1:0][1:0]    rd_a;
    logic [MAX_WIDTH-1:0][1:0]    rd_b;
    logic [MAX_WIDTH-1:0][1:0]    rd_row;
    logic [MAX_WIDTH-1:0][1:0]    new_row;
    logic [MAX_WIDTH-1:0][1:0]    cell_row;
    logic [MAX_WIDTH-1:0][1:0]    wdata;
    logic [MAX_WIDTH-1:0]         in_w;
    logic [MAX_WIDTH-1:0]         cell_mask;
    logic [MAX_WIDTH-1:0]         wmask;
    logic [MAX_WIDTH-1:0]         lane_chg;
    logic [MAX_WIDTH+1:0]         ha_x;
    logic [MAX_WIDTH+1:0]         hm_x;
    logic [MAX_WIDTH+1:0]         hb_x;

    logic [CMP_W-1:0]             wx;
    logic [CMP_W-1:0]             hx;
    logic [CMP_W-1:0]             w_eff;
    logic [CMP_W-1:0]             h_eff;
    logic [RA_W-1:0]              row_addr;
    logic [CA_W-1:0]              col_addr;
    logic [RA_W-1:0]              wr_row;
    logic [RA_W-1:0]              waddr;
    logic [RA_W-1:0]              raddr;
    logic                         sweep_wr;
    logic                         border_row;
    logic                         row_chg;
    logic                         rd_en;
    logic                         we_a;
    logic                         we_b;

    // effective grid size, clamped to the legal range
    assign wx = CMP_W'(width_reg);
    assign hx = CMP_W'(height_reg);
    assign w_eff = (wx < CMP_W'(wwgs_pkg::MIN_DIM)) ? CMP_W'(wwgs_pkg::MIN_DIM) :
                   (wx > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : wx;
    assign h_eff = (hx < CMP_W'(wwgs_pkg::MIN_DIM)) ? CMP_W'(wwgs_pkg::MIN_DIM) :
                   (hx > CMP_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT) : hx;

    assign row_addr = RA_W'(row_index);
    assign col_addr = CA_W'(col_index);

    assign sweep_wr = cmd.sweep && (t_reg >= T_W'(2));
    assign wr_row = RA_W'(t_reg - T_W'(2));
    assign border_row = (t_reg == T_W'(2)) || (t_reg == T_W'(h_eff) + T_W'(1));
    assign rd_row = sel_reg ? rd_b : rd_a;

    assign stat.addr_bad = (CMP_W'(row_index) >= h_eff) || (CMP_W'(col_index) >= w_eff);
    assign stat.gen_zero = (generation_count == '0);
    assign stat.sweep_last = (t_reg == T_W'(h_eff) + T_W'(1));
    assign stat.gens_last = (gen_cnt_reg == wwgs_pkg::GEN_W'(1));
    assign row_chg = sweep_wr && (|lane_chg);
    assign stat.changed_any = changed_reg || row_chg;

    // neighbor head maps padded with a blank lane on each side
    always_comb
    begin
        ha_x = '0;
        hm_x = '0;
        hb_x = '0;
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            ha_x[c+1] = (above_reg[c] == wwgs_pkg::CELL_HEAD);
            hm_x[c+1] = (mid_reg[c] == wwgs_pkg::CELL_HEAD);
            hb_x[c+1] = (rd_row[c] == wwgs_pkg::CELL_HEAD);
        end
    end

    for (genvar c = 0; c < MAX_WIDTH; c++)
    begin : g_lane
        logic [7:0] nb;
        logic       border;
        assign nb = {ha_x[c], ha_x[c+1], ha_x[c+2], hm_x[c], hm_x[c+2],
                     hb_x[c], hb_x[c+1], hb_x[c+2]};
        assign in_w[c] = (CMP_W'(c) < w_eff);
        assign border = border_row || (c == 0) || (CMP_W'(c) == w_eff - CMP_W'(1));
        assign new_row[c] = border ? mid_reg[c] : wwgs_pkg::next_cell(mid_reg[c], nb);
        assign lane_chg[c] = in_w[c] && (new_row[c] != mid_reg[c]);
        assign cell_mask[c] = (CA_W'(c) == col_addr);
        assign cell_row[c] = cell_in;
    end

    // store port steering: cell writes go to the current store, sweeps to the other
    assign we_a = (cmd.cell_wr && !sel_reg) || (sweep_wr && sel_reg);
    assign we_b = (cmd.cell_wr && sel_reg) || (sweep_wr && !sel_reg);
    assign waddr = cmd.cell_wr ? row_addr : wr_row;
    assign wmask = cmd.cell_wr ? cell_mask : in_w;
    assign wdata = cmd.cell_wr ? cell_row : new_row;
    assign rd_en = cmd.cell_rd || (cmd.sweep && (t_reg < T_W'(h_eff)));
    assign raddr = cmd.cell_rd ? row_addr : RA_W'(t_reg);

    wwgs_row_ram #(
        .WORDS (MAX_HEIGHT),
        .LANES (MAX_WIDTH)
    ) u_store_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wmask (wmask),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (rd_a)
    );

    wwgs_row_ram #(
        .WORDS (MAX_HEIGHT),
        .LANES (MAX_WIDTH)
    ) u_store_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wmask (wmask),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (rd_b)
    );

    always_comb
    begin
        sel_next = sel_reg;
        t_next = t_reg;
        gen_cnt_next = gen_cnt_reg;
        changed_next = changed_reg;
        if (cmd.run_start)
        begin
            t_next = '0;
            gen_cnt_next = generation_count;
            changed_next = 1'b0;
        end
        else if (cmd.gen_end)
        begin
            t_next = '0;
            gen_cnt_next = gen_cnt_reg - wwgs_pkg::GEN_W'(1);
            changed_next = 1'b0;
            // fixed point: remaining generations only swap the stores
            sel_next = stat.changed_any ? ~sel_reg : (sel_reg ^ gen_cnt_reg[0]);
        end
        else if (cmd.sweep)
        begin
            t_next = t_reg + T_W'(1);
            changed_next = changed_reg || row_chg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= wwgs_pkg::DIM_RESET;
            height_reg <= wwgs_pkg::DIM_RESET;
            sel_reg <= 1'b0;
            t_reg <= '0;
            gen_cnt_reg <= '0;
            changed_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (wwgs_pkg::cfg_idx_t'(cfg_index))
                    wwgs_pkg::CFG_WIDTH:  width_reg <= cfg_wdata;
                    wwgs_pkg::CFG_HEIGHT: height_reg <= cfg_wdata;
                    default:              width_reg <= width_reg;
                endcase
            end
            sel_reg <= sel_next;
            t_reg <= t_next;
            gen_cnt_reg <= gen_cnt_next;
            changed_reg <= changed_next;
        end
    end

    // row window and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.sweep)
        begin
            above_reg <= mid_reg;
            mid_reg <= rd_row;
        end
        if (cmd.cell_rd)
        begin
            col_reg <= col_addr;
        end
        if (cmd.load_out)
        begin
            case (cmd.out_sel)
                wwgs_pkg::OUT_CELL:
                begin
                    cell_out_reg <= rd_row[col_reg];
                    status_reg <= 1'b0;
                end
                wwgs_pkg::OUT_BAD:
                begin
                    cell_out_reg <= wwgs_pkg::CELL_BLANK;
                    status_reg <= 1'b1;
                end
                default:
                begin
                    cell_out_reg <= wwgs_pkg::CELL_BLANK;
                    status_reg <= 1'b0;
                end
            endcase
        end
    end

    assign cell_out = cell_out_reg;
    assign status = status_reg;

endmodule

FILE: design/wwgs_ctrl.sv
// controller: request decode, run sequencing and output handshake
module wwgs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            req_type,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  wwgs_pkg::dp_stat_t    stat,
    output wwgs_pkg::dp_cmd_t     cmd
);

    `include "wireworld_grid_stepper_assert.svh"

    wwgs_pkg::state_t state_reg;
    wwgs_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             accept;

    assign in_ready = (state_reg == wwgs_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wwgs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.out_sel = wwgs_pkg::OUT_ZERO;
        unique case (state_reg)
            wwgs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (wwgs_pkg::req_t'(req_type))
                        wwgs_pkg::REQ_WRITE:
                        begin
                            cmd.load_out = 1'b1;
                            if (stat.addr_bad)
                            begin
                                cmd.out_sel = wwgs_pkg::OUT_BAD;
                            end
                            else
                            begin
                                cmd.cell_wr = 1'b1;
                            end
                        end
                        wwgs_pkg::REQ_READ:
                        begin
                            if (stat.addr_bad)
                            begin
                                cmd.load_out = 1'b1;
                                cmd.out_sel = wwgs_pkg::OUT_BAD;
                            end
                            else
                            begin
                                cmd.cell_rd = 1'b1;
                                state_next = wwgs_pkg::ST_READ;
                            end
                        end
                        wwgs_pkg::REQ_RUN:
                        begin
                            if (stat.gen_zero)
                            begin
                                cmd.load_out = 1'b1;
                            end
                            else
                            begin
                                cmd.run_start = 1'b1;
                                state_next = wwgs_pkg::ST_RUN;
                            end
                        end
                        default:
                        begin
                            cmd.load_out = 1'b1;
                        end
                    endcase
                end
            end
            wwgs_pkg::ST_READ:
            begin
                cmd.load_out = 1'b1;
                cmd.out_sel = wwgs_pkg::OUT_CELL;
                state_next = wwgs_pkg::ST_IDLE;
            end
            wwgs_pkg::ST_RUN:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.gen_end = 1'b1;
                    if (!stat.changed_any || stat.gens_last)
                    begin
                        cmd.load_out = 1'b1;
                        state_next = wwgs_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = wwgs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // a result only lands in a free output slot
    `WWGS_ASSERT_NOW(a_load_slot_free, clk, rst_n, cmd.load_out, (!out_valid_reg || out_ready))
    // a cell read answers on the following cycle
    `WWGS_ASSERT_NEXT(a_read_one_cycle, clk, rst_n, (state_reg == wwgs_pkg::ST_READ), ((state_reg == wwgs_pkg::ST_IDLE) && out_valid_reg))
    // an empty run answers at once
    `WWGS_ASSERT_NEXT(a_empty_run, clk, rst_n, (accept && (req_type == wwgs_pkg::REQ_RUN) && stat.gen_zero), (out_valid_reg && (state_reg == wwgs_pkg::ST_IDLE)))

endmodule

FILE: design/wireworld_grid_stepper.sv
// wireworld grid stepper: one request of write, read or run, one response each
// write, bad address, unknown type, zero-generation run: response in the cycle after the request
// read: row read registered from the current store, then the cell registered into the response
// run of g generations: g sweeps over the grid, one grid row per cycle
// a run ends early after the first generation that changes nothing
// one request at a time; a request is taken once the previous response leaves
// reset: select store a, width and height 64, stores undefined until written
module wireworld_grid_stepper #(
    parameter int MAX_WIDTH = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [wwgs_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   req_type,
    input  logic [5:0]                   row_index,
    input  logic [5:0]                   col_index,
    input  logic [1:0]                   cell_in,
    input  logic [wwgs_pkg::GEN_W-1:0]   generation_count,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   cell_out,
    output logic                         status
);

    wwgs_pkg::dp_cmd_t  cmd;
    wwgs_pkg::dp_stat_t stat;

    wwgs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    wwgs_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .row_index        (row_index),
        .col_index        (col_index),
        .cell_in          (cell_in),
        .generation_count (generation_count),
        .cmd              (cmd),
        .stat             (stat),
        .cell_out         (cell_out),
        .status           (status)
    );

endmodule
